/* src/dpp_pkg.sv */
// shared widths, constants and codes of the drive position controller
`timescale 1ns / 1ps

package dpp_pkg;

  // fixed field and state widths
  localparam int POSITION_WIDTH = 24;
  localparam int ACCUM_WIDTH    = 32;
  localparam int GAIN_WIDTH     = 16;
  localparam int TOL_WIDTH      = 8;
  localparam int POWER_WIDTH    = 8;

  // apb register file
  localparam int ADDR_WIDTH = 4;
  localparam int DATA_WIDTH = 32;

  // derived datapath widths
  localparam int SUM_W   = POSITION_WIDTH + 3;   // sum of six positions
  localparam int MAG_W   = POSITION_WIDTH + 2;   // magnitude of that sum
  localparam int HALF_W  = POSITION_WIDTH + 1;   // magnitude halved, then divided by three
  localparam int QUO_W   = POSITION_WIDTH;       // magnitude of the average
  localparam int DIVP_W  = 2 * HALF_W;           // reciprocal product
  localparam int RECIP_SHIFT = HALF_W + 1;
  localparam int ERR_W   = POSITION_WIDTH + 1;
  localparam int DIFF_W  = POSITION_WIDTH + 2;
  localparam int ACC_SUM_W = ((ACCUM_WIDTH > ERR_W) ? ACCUM_WIDTH : ERR_W) + 1;
  localparam int PP_W    = GAIN_WIDTH + 1 + ERR_W;
  localparam int PD_W    = GAIN_WIDTH + 1 + DIFF_W;
  localparam int PI_W    = GAIN_WIDTH + 1 + ACCUM_WIDTH;
  localparam int BOUND_EXP = 52;
  localparam int TERM_W  = BOUND_EXP + 2;
  localparam int EXT_W   = 66;
  localparam int TOT_W   = TERM_W + 2;
  localparam int GAIN_SHIFT  = 8;
  localparam int POWER_LIMIT = 100;

  // ceil(2^(HALF_W+1) / 3), exact division by three for any HALF_W-bit value
  localparam logic [HALF_W-1:0] RECIP3 =
    HALF_W'(((EXT_W'(1) << RECIP_SHIFT) + EXT_W'(2)) / EXT_W'(3));

  // bound applied to the integral product
  localparam logic signed [EXT_W-1:0] TERM_BOUND_HI =
    {{(EXT_W - BOUND_EXP - 1){1'b0}}, 1'b1, {BOUND_EXP{1'b0}}};
  localparam logic signed [EXT_W-1:0] TERM_BOUND_LO = -TERM_BOUND_HI;

  // register reset values
  localparam logic [GAIN_WIDTH-1:0] GAIN_P_RESET    = 16'd128;
  localparam logic [GAIN_WIDTH-1:0] GAIN_I_RESET    = 16'd0;
  localparam logic [GAIN_WIDTH-1:0] GAIN_D_RESET    = 16'd26;
  localparam logic [TOL_WIDTH-1:0]  TOLERANCE_RESET = 8'd5;

  typedef enum logic [1:0] {
    REG_GAIN_P    = 2'd0,
    REG_GAIN_I    = 2'd1,
    REG_GAIN_D    = 2'd2,
    REG_TOLERANCE = 2'd3
  } reg_idx_e;

  typedef enum logic {
    KIND_START  = 1'b0,
    KIND_SAMPLE = 1'b1
  } kind_e;

endpackage

/* src/dpp_in_if.sv */
// input channel: start and encoder sample beats
`timescale 1ns / 1ps

interface dpp_in_if import dpp_pkg::*; ();
  logic                             valid;
  logic                             ready;
  logic                             kind;
  logic signed [POSITION_WIDTH-1:0] target;
  logic signed [POSITION_WIDTH-1:0] pos_left_front;
  logic signed [POSITION_WIDTH-1:0] pos_left_middle;
  logic signed [POSITION_WIDTH-1:0] pos_left_back;
  logic signed [POSITION_WIDTH-1:0] pos_right_front;
  logic signed [POSITION_WIDTH-1:0] pos_right_middle;
  logic signed [POSITION_WIDTH-1:0] pos_right_back;

  modport source (
    output valid, kind, target, pos_left_front, pos_left_middle, pos_left_back,
           pos_right_front, pos_right_middle, pos_right_back,
    input  ready
  );

  modport sink (
    input  valid, kind, target, pos_left_front, pos_left_middle, pos_left_back,
           pos_right_front, pos_right_middle, pos_right_back,
    output ready
  );
endinterface

/* src/dpp_out_if.sv */
// output channel: drive command beats
`timescale 1ns / 1ps

interface dpp_out_if import dpp_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [POWER_WIDTH-1:0] power;
  logic                          finished;

  modport source (
    output valid, power, finished,
    input  ready
  );

  modport sink (
    input  valid, power, finished,
    output ready
  );
endinterface

/* src/drive_position_pid.sv */
// position pid with output clamp for a six-motor tank drive
`timescale 1ns / 1ps

// drive_position_pid takes one beat per clock unless the result side stalls it and
// returns exactly one result beat per input beat, in order. A start beat (kind 0) loads
// the move distance, clears the integral and the last error and answers power 0;
// it answers finished when the distance is already within tolerance. A sample beat
// (kind 1) averages the six encoder positions (truncating toward zero), forms
// error, saturating integral and difference, and answers
// clamp((gp*err + gi*integral + gd*diff) >>> 8, -100, 100); once the error is
// within tolerance it answers power 0 with finished set and the drive goes idle.
// Samples while idle answer power 0, finished 0. The six-register pipeline
// (input, sum, divide-by-six, state update, gain products, sum and clamp) moves
// on every cycle that the next register is free, so throughput is one beat per
// cycle and the controller state is read and written in a single stage. Gains
// and tolerance sit on an apb port at byte addresses 0, 4, 8 and 12; the user must
// write them only while no beat is in flight, which the block itself does not enforce.
module drive_position_pid
  import dpp_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  dpp_in_if.sink                item_i,
  dpp_out_if.source             result_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_WIDTH-1:0] paddr,
  input  logic [DATA_WIDTH-1:0] pwdata,
  output logic [DATA_WIDTH-1:0] prdata,
  output logic                  pready
);

  // ------------------------------------------------------------------
  // pipeline stage payloads
  // ------------------------------------------------------------------
  typedef struct packed {
    kind_e                            kind;
    logic signed [POSITION_WIDTH-1:0] target;
    logic signed [POSITION_WIDTH-1:0] lf;
    logic signed [POSITION_WIDTH-1:0] lm;
    logic signed [POSITION_WIDTH-1:0] lb;
    logic signed [POSITION_WIDTH-1:0] rf;
    logic signed [POSITION_WIDTH-1:0] rm;
    logic signed [POSITION_WIDTH-1:0] rb;
  } st_in_t;

  typedef struct packed {
    kind_e                            kind;
    logic signed [POSITION_WIDTH-1:0] target;
    logic signed [SUM_W-1:0]          sum;
  } st_sum_t;

  typedef struct packed {
    kind_e                            kind;
    logic signed [POSITION_WIDTH-1:0] target;
    logic                             neg;
    logic [QUO_W-1:0]                 quo;
  } st_avg_t;

  typedef struct packed {
    logic                          zero;
    logic                          done;
    logic signed [ERR_W-1:0]       err;
    logic signed [ACCUM_WIDTH-1:0] acc;
    logic signed [DIFF_W-1:0]      diff;
  } st_pid_t;

  typedef struct packed {
    logic                     zero;
    logic                     done;
    logic signed [PP_W-1:0]   tp;
    logic signed [TERM_W-1:0] ti;
    logic signed [PD_W-1:0]   td;
  } st_mul_t;

  // ------------------------------------------------------------------
  // configuration registers
  // ------------------------------------------------------------------
  logic [GAIN_WIDTH-1:0] gain_p_q, gain_i_q, gain_d_q;
  logic [TOL_WIDTH-1:0]  tolerance_q;
  logic                  cfg_wr;
  reg_idx_e              cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_e'(paddr[ADDR_WIDTH-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q    <= GAIN_P_RESET;
      gain_i_q    <= GAIN_I_RESET;
      gain_d_q    <= GAIN_D_RESET;
      tolerance_q <= TOLERANCE_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_GAIN_P:    gain_p_q    <= pwdata[GAIN_WIDTH-1:0];
        REG_GAIN_I:    gain_i_q    <= pwdata[GAIN_WIDTH-1:0];
        REG_GAIN_D:    gain_d_q    <= pwdata[GAIN_WIDTH-1:0];
        REG_TOLERANCE: tolerance_q <= pwdata[TOL_WIDTH-1:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_GAIN_P:    prdata = DATA_WIDTH'(gain_p_q);
      REG_GAIN_I:    prdata = DATA_WIDTH'(gain_i_q);
      REG_GAIN_D:    prdata = DATA_WIDTH'(gain_d_q);
      REG_TOLERANCE: prdata = DATA_WIDTH'(tolerance_q);
      default:       prdata = '0;
    endcase
  end

  // ------------------------------------------------------------------
  // stage advance: a stage loads when it is empty or its successor moves
  // ------------------------------------------------------------------
  logic v0_q, v1_q, v2_q, v3_q, v4_q, v5_q;
  logic en0, en1, en2, en3, en4, en5;

  assign en5 = !v5_q || result_o.ready;
  assign en4 = !v4_q || en5;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign en0 = !v0_q || en1;

  assign item_i.ready = en0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (en0) v0_q <= item_i.valid;
      if (en1) v1_q <= v0_q;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
    end
  end

  // ------------------------------------------------------------------
  // stage 0: input register
  // ------------------------------------------------------------------
  st_in_t s0_q;

  always_ff @(posedge clk_i) begin
    if (en0) begin
      s0_q.kind   <= kind_e'(item_i.kind);
      s0_q.target <= item_i.target;
      s0_q.lf     <= item_i.pos_left_front;
      s0_q.lm     <= item_i.pos_left_middle;
      s0_q.lb     <= item_i.pos_left_back;
      s0_q.rf     <= item_i.pos_right_front;
      s0_q.rm     <= item_i.pos_right_middle;
      s0_q.rb     <= item_i.pos_right_back;
    end
  end

  // ------------------------------------------------------------------
  // stage 1: sum of the six encoders
  // ------------------------------------------------------------------
  st_sum_t s1_q, s1_d;

  always_comb begin
    s1_d.kind   = s0_q.kind;
    s1_d.target = s0_q.target;
    s1_d.sum    = SUM_W'(s0_q.lf) + SUM_W'(s0_q.lm) + SUM_W'(s0_q.lb)
                + SUM_W'(s0_q.rf) + SUM_W'(s0_q.rm) + SUM_W'(s0_q.rb);
  end

  always_ff @(posedge clk_i) begin
    if (en1) s1_q <= s1_d;
  end

  // ------------------------------------------------------------------
  // stage 2: divide by six on the magnitude, sign kept aside
  // |s| / 6 = (|s| >> 1) / 3, the divide by three is a reciprocal multiply
  // ------------------------------------------------------------------
  st_avg_t           s2_q, s2_d;
  logic [SUM_W-1:0]  sum_abs;
  logic [HALF_W-1:0] sum_half;
  logic [DIVP_W-1:0] div_prod;

  assign sum_abs  = s1_q.sum[SUM_W-1] ? -s1_q.sum : s1_q.sum;
  assign sum_half = sum_abs[MAG_W-1:1];
  assign div_prod = DIVP_W'(sum_half) * DIVP_W'(RECIP3);

  always_comb begin
    s2_d.kind   = s1_q.kind;
    s2_d.target = s1_q.target;
    s2_d.neg    = s1_q.sum[SUM_W-1];
    s2_d.quo    = div_prod[RECIP_SHIFT +: QUO_W];
  end

  always_ff @(posedge clk_i) begin
    if (en2) s2_q <= s2_d;
  end

  // ------------------------------------------------------------------
  // stage 3: controller state, the only place it is read and written
  // ------------------------------------------------------------------
  logic signed [POSITION_WIDTH-1:0] goal_q, goal_d;
  logic signed [ACCUM_WIDTH-1:0]    error_sum_q, error_sum_d;
  logic signed [ERR_W-1:0]          prev_err_q, prev_err_d;
  logic                             moving_q, moving_d;

  st_pid_t                  s3_q, s3_d;
  logic signed [ERR_W-1:0]  avg_pos, avg, err, tgt_ext;
  logic [ERR_W-1:0]         err_mag, tgt_mag, tol_ext;
  logic signed [ACC_SUM_W-1:0]   acc_wide;
  logic signed [ACCUM_WIDTH-1:0] acc_sat;
  logic                          acc_ovf;
  logic signed [DIFF_W-1:0]      diff;
  logic                          in_tol;

  assign avg_pos = $signed(ERR_W'(s2_q.quo));
  assign avg     = s2_q.neg ? -avg_pos : avg_pos;
  assign err     = ERR_W'(goal_q) - avg;
  assign err_mag = err[ERR_W-1] ? -err : err;
  assign tgt_ext = ERR_W'(s2_q.target);
  assign tgt_mag = tgt_ext[ERR_W-1] ? -tgt_ext : tgt_ext;
  assign tol_ext = ERR_W'(tolerance_q);
  assign in_tol  = err_mag <= tol_ext;

  // saturating integral: overflow when the wide sum does not fit the low bits
  assign acc_wide = ACC_SUM_W'(error_sum_q) + ACC_SUM_W'(err);
  assign acc_ovf  = acc_wide != ACC_SUM_W'($signed(acc_wide[ACCUM_WIDTH-1:0]));
  always_comb begin
    if (!acc_ovf) begin
      acc_sat = acc_wide[ACCUM_WIDTH-1:0];
    end else if (acc_wide[ACC_SUM_W-1]) begin
      acc_sat = {1'b1, {(ACCUM_WIDTH-1){1'b0}}};
    end else begin
      acc_sat = {1'b0, {(ACCUM_WIDTH-1){1'b1}}};
    end
  end

  assign diff = DIFF_W'(err) - DIFF_W'(prev_err_q);

  always_comb begin
    goal_d      = goal_q;
    error_sum_d = error_sum_q;
    prev_err_d  = prev_err_q;
    moving_d    = moving_q;
    s3_d.err    = err;
    s3_d.acc    = acc_sat;
    s3_d.diff   = diff;
    s3_d.zero   = 1'b1;
    s3_d.done   = 1'b0;
    if (s2_q.kind == KIND_START) begin
      // new move: a distance already inside tolerance finishes at once
      goal_d      = s2_q.target;
      error_sum_d = '0;
      prev_err_d  = '0;
      moving_d    = tgt_mag > tol_ext;
      s3_d.done   = !(tgt_mag > tol_ext);
    end else if (moving_q) begin
      error_sum_d = acc_sat;
      prev_err_d  = err;
      moving_d    = !in_tol;
      s3_d.zero   = in_tol;
      s3_d.done   = in_tol;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      goal_q      <= '0;
      error_sum_q <= '0;
      prev_err_q  <= '0;
      moving_q    <= 1'b0;
    end else if (en3 && v2_q) begin
      goal_q      <= goal_d;
      error_sum_q <= error_sum_d;
      prev_err_q  <= prev_err_d;
      moving_q    <= moving_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3) s3_q <= s3_d;
  end

  // ------------------------------------------------------------------
  // stage 4: gain products, integral term bounded
  // ------------------------------------------------------------------
  st_mul_t                     s4_q, s4_d;
  logic signed [GAIN_WIDTH:0]  gp_s, gi_s, gd_s;
  logic signed [PI_W-1:0]      ti_raw;
  logic signed [EXT_W-1:0]     ti_ext, ti_bnd;

  assign gp_s   = {1'b0, gain_p_q};
  assign gi_s   = {1'b0, gain_i_q};
  assign gd_s   = {1'b0, gain_d_q};
  assign ti_raw = PI_W'(gi_s) * PI_W'(s3_q.acc);
  assign ti_ext = EXT_W'(ti_raw);

  always_comb begin
    if (ti_ext > TERM_BOUND_HI) begin
      ti_bnd = TERM_BOUND_HI;
    end else if (ti_ext < TERM_BOUND_LO) begin
      ti_bnd = TERM_BOUND_LO;
    end else begin
      ti_bnd = ti_ext;
    end
  end

  always_comb begin
    s4_d.zero = s3_q.zero;
    s4_d.done = s3_q.done;
    s4_d.tp   = PP_W'(gp_s) * PP_W'(s3_q.err);
    s4_d.ti   = ti_bnd[TERM_W-1:0];
    s4_d.td   = PD_W'(gd_s) * PD_W'(s3_q.diff);
  end

  always_ff @(posedge clk_i) begin
    if (en4) s4_q <= s4_d;
  end

  // ------------------------------------------------------------------
  // stage 5: sum, floor shift, clamp, result register
  // ------------------------------------------------------------------
  localparam logic signed [TOT_W-1:0] PWR_HI = TOT_W'(POWER_LIMIT);
  localparam logic signed [TOT_W-1:0] PWR_LO = -PWR_HI;

  logic signed [TOT_W-1:0]       total, shifted, clamped;
  logic signed [POWER_WIDTH-1:0] power_q, power_d;
  logic                          finished_q;

  assign total   = TOT_W'(s4_q.tp) + TOT_W'(s4_q.ti) + TOT_W'(s4_q.td);
  assign shifted = total >>> GAIN_SHIFT;

  always_comb begin
    if (shifted > PWR_HI) begin
      clamped = PWR_HI;
    end else if (shifted < PWR_LO) begin
      clamped = PWR_LO;
    end else begin
      clamped = shifted;
    end
    power_d = s4_q.zero ? '0 : clamped[POWER_WIDTH-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en5) begin
      power_q    <= power_d;
      finished_q <= s4_q.done;
    end
  end

  assign result_o.valid    = v5_q;
  assign result_o.power    = power_q;
  assign result_o.finished = finished_q;

endmodule

/* src/dpp_checker.sv */
// port-level checks for the drive position controller, bound to the top level
`timescale 1ns / 1ps

module dpp_checker
  import dpp_pkg::*;
(
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic signed [POWER_WIDTH-1:0] power_i,
  input logic                          finished_i
);

  localparam logic signed [POWER_WIDTH-1:0] PWR_HI = POWER_WIDTH'(POWER_LIMIT);
  localparam logic signed [POWER_WIDTH-1:0] PWR_LO = -PWR_HI;

  // beats accepted but not yet answered
  logic [3:0] pending_q, pending_d;
  logic       in_beat, out_beat;

  assign in_beat  = in_valid_i && in_ready_i;
  assign out_beat = out_valid_i && out_ready_i;

  always_comb begin
    pending_d = pending_q;
    if (in_beat && !out_beat) pending_d = pending_q + 4'd1;
    if (!in_beat && out_beat) pending_d = pending_q - 4'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(power_i) && $stable(finished_i))
    else $error("result beat changed while stalled");

  a_finish_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && finished_i |-> power_i == '0)
    else $error("finished beat with nonzero power");

  a_power_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> power_i <= PWR_HI && power_i >= PWR_LO)
    else $error("power outside clamp range");

  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pending_q != '0)
    else $error("result beat without an accepted input beat");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input stalled while result side is free");

endmodule

bind drive_position_pid dpp_checker u_dpp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (item_i.valid),
  .in_ready_i  (item_i.ready),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .power_i     (result_o.power),
  .finished_i  (result_o.finished)
);
